@@ rtl/m68kc_pkg.sv @@
`default_nettype none

package m68kc_pkg;

  // Operation class reported with each result
  typedef enum logic [2:0] {
    KIND_AND_REG = 3'd0,
    KIND_AND_MEM = 3'd1,
    KIND_MULU    = 3'd2,
    KIND_MULS    = 3'd3,
    KIND_ABCD    = 3'd4,
    KIND_EXG     = 3'd5
  } op_kind_t;

  // Condition code bit positions
  localparam int unsigned FLAG_X = 4;
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_C = 0;

  // Operand size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_MUL  = 2'd3;

  // Legal exchange opmodes: data-data, address-address, data-address
  localparam logic [4:0] EXG_DD = 5'h08;
  localparam logic [4:0] EXG_AA = 5'h09;
  localparam logic [4:0] EXG_DA = 5'h11;

  // Decimal adjust constants
  localparam logic [5:0] BCD_LO_LIMIT = 6'h0a;
  localparam logic [5:0] BCD_LO_ADJ   = 6'h06;
  localparam logic [9:0] BCD_HI_LIMIT = 10'h0a0;
  localparam logic [9:0] BCD_HI_ADJ   = 10'h060;
  localparam logic [9:0] BCD_CARRY    = 10'h100;
  localparam logic [7:0] BCD_V_BASE   = 8'h80;
  localparam logic [3:0] BCD_V_CAP    = 4'd5;

endpackage

`default_nettype wire

@@ rtl/m68k_line_c_execute_core.sv @@
// Line-C execute core: MULU, MULS, AND to register, AND to memory, ABCD, EXG.
//
// Input channel (in_valid/in_ready): one transaction carries both opcode bytes,
// the fetched source and destination operands and the incoming condition codes.
// Result channel (out_valid/out_ready): exactly one transaction per input with
// the result, the exchange partner value, the operation kind, the new flags
// and the illegal flag for a bad exchange opmode.
//
// An input register feeds decode, the 17x17 multiplier and the BCD adder, whose
// outputs land in the result register. Throughput is one transaction per cycle
// while the receiver keeps out_ready high; the single multiplier between the
// two registers sets the cycle time.
//
// Reset (rst_n low, synchronous) empties both registers; no result is pending
// afterwards. When the receiver stalls, the result register holds its value and
// the input register keeps one more transaction, so two are buffered before
// in_ready drops.
`default_nettype none

module m68k_line_c_execute_core
  import m68kc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_opword_high,
  input  wire logic [7:0]  in_opword_low,
  input  wire logic [31:0] in_src_value,
  input  wire logic [31:0] in_dst_value,
  input  wire logic [4:0]  in_ccr_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_result,
  output logic [31:0]      out_swap_value,
  output logic [2:0]       out_op_kind,
  output logic [4:0]       out_ccr_out,
  output logic             out_illegal
);

  logic        s1_valid_r;
  logic [7:0]  s1_hi_r;
  logic [7:0]  s1_lo_r;
  logic [31:0] s1_src_r;
  logic [31:0] s1_dst_r;
  logic [4:0]  s1_ccr_r;
  logic        out_valid_r;
  logic [31:0] result_r;
  logic [31:0] swap_r;
  op_kind_t    kind_r;
  logic [4:0]  ccr_r;
  logic        illegal_r;

  logic        s2_ready;
  logic        s1_load;
  logic        s2_load;

  logic [31:0] result_nxt;
  logic [31:0] swap_nxt;
  op_kind_t    kind_nxt;
  logic [4:0]  ccr_nxt;
  logic        illegal_nxt;

  // Handshake: each stage takes new data when empty or draining
  assign s2_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign s1_load  = in_valid && in_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s2_ready) out_valid_r <= s1_valid_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_hi_r  <= in_opword_high;
      s1_lo_r  <= in_opword_low;
      s1_src_r <= in_src_value;
      s1_dst_r <= in_dst_value;
      s1_ccr_r <= in_ccr_in;
    end
  end

  // Decode and execute
  always_comb begin
    logic              grp1;
    logic              mul_op;
    logic [1:0]        size;
    logic [31:0]       and_v;
    logic              and_n;
    logic              mul_signed;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic [31:0]       prod;
    logic [5:0]        bcd_lo;
    logic [9:0]        bcd_hi;
    logic [7:0]        bcd_byte;
    logic [7:0]        vmax;
    logic              bcd_c;
    logic [4:0]        opmode;
    logic [4:0]        bcd_f;

    grp1   = s1_hi_r[0];
    mul_op = (s1_lo_r[7:6] == SIZE_MUL);
    size   = s1_lo_r[7:6];

    // Sized AND
    and_v = s1_src_r & s1_dst_r;
    case (size)
      SIZE_BYTE: begin
        and_v = {24'd0, and_v[7:0]};
        and_n = and_v[7];
      end
      SIZE_WORD: begin
        and_v = {16'd0, and_v[15:0]};
        and_n = and_v[15];
      end
      default: and_n = and_v[31];
    endcase

    // 16x16 multiply, sign extended by one bit for MULS
    mul_signed = grp1;
    mul_a = $signed({mul_signed & s1_src_r[15], s1_src_r[15:0]});
    mul_b = $signed({mul_signed & s1_dst_r[15], s1_dst_r[15:0]});
    mul_p = mul_a * mul_b;
    prod  = mul_p[31:0];

    // Decimal add with extend
    bcd_lo = {2'd0, s1_src_r[3:0]} + {2'd0, s1_dst_r[3:0]} + {5'd0, s1_ccr_r[FLAG_X]};
    if (bcd_lo >= BCD_LO_LIMIT) bcd_lo = bcd_lo + BCD_LO_ADJ;
    bcd_hi = {2'd0, s1_src_r[7:4], 4'd0} + {2'd0, s1_dst_r[7:4], 4'd0}
           + {4'd0, bcd_lo[5:4], 4'd0};
    if (bcd_hi >= BCD_HI_LIMIT) bcd_hi = bcd_hi + BCD_HI_ADJ;
    bcd_c    = (bcd_hi >= BCD_CARRY);
    bcd_byte = {bcd_hi[7:4], bcd_lo[3:0]};
    if (!s1_dst_r[7]) begin
      vmax = BCD_V_BASE + {4'd0, (s1_dst_r[3:0] >= BCD_V_CAP) ? BCD_V_CAP : s1_dst_r[3:0]};
    end else begin
      vmax = s1_dst_r[7:0];
    end
    bcd_f = 5'd0;
    bcd_f[FLAG_X] = bcd_c;
    bcd_f[FLAG_C] = bcd_c;
    bcd_f[FLAG_Z] = s1_ccr_r[FLAG_Z] && (bcd_byte == 8'd0);
    bcd_f[FLAG_N] = bcd_byte[7];
    bcd_f[FLAG_V] = bcd_byte[7] && (bcd_byte <= vmax);

    opmode = s1_lo_r[7:3];

    // Select by operation
    swap_nxt    = 32'd0;
    illegal_nxt = 1'b0;
    result_nxt  = and_v;
    kind_nxt    = KIND_AND_REG;
    ccr_nxt     = s1_ccr_r;
    if (mul_op) begin
      kind_nxt   = grp1 ? KIND_MULS : KIND_MULU;
      result_nxt = prod;
    end else if (grp1 && s1_lo_r[7:4] == 4'd0) begin
      kind_nxt   = KIND_ABCD;
      result_nxt = {24'd0, bcd_byte};
    end else if (grp1 && s1_lo_r[5:4] == 2'd0) begin
      kind_nxt = KIND_EXG;
      if (opmode == EXG_DD || opmode == EXG_AA || opmode == EXG_DA) begin
        result_nxt = s1_src_r;
        swap_nxt   = s1_dst_r;
      end else begin
        illegal_nxt = 1'b1;
        result_nxt  = s1_dst_r;
        swap_nxt    = s1_src_r;
      end
    end else begin
      kind_nxt = grp1 ? KIND_AND_MEM : KIND_AND_REG;
    end

    // Flags: N/Z from the value, V/C cleared, X kept, except ABCD and EXG
    if (kind_nxt == KIND_ABCD) begin
      ccr_nxt = bcd_f;
    end else if (kind_nxt != KIND_EXG) begin
      ccr_nxt = 5'd0;
      ccr_nxt[FLAG_X] = s1_ccr_r[FLAG_X];
      ccr_nxt[FLAG_N] = mul_op ? prod[31] : and_n;
      ccr_nxt[FLAG_Z] = (result_nxt == 32'd0);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      result_r  <= result_nxt;
      swap_r    <= swap_nxt;
      kind_r    <= kind_nxt;
      ccr_r     <= ccr_nxt;
      illegal_r <= illegal_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result     = result_r;
  assign out_swap_value = swap_r;
  assign out_op_kind    = kind_r;
  assign out_ccr_out    = ccr_r;
  assign out_illegal    = illegal_r;

endmodule

`default_nettype wire

@@ rtl/m68kc_checker.sv @@
`default_nettype none

module m68kc_checker
  import m68kc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_opword_high,
  input wire logic [7:0]  in_opword_low,
  input wire logic [31:0] in_src_value,
  input wire logic [31:0] in_dst_value,
  input wire logic [4:0]  in_ccr_in,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result,
  input wire logic [31:0] out_swap_value,
  input wire logic [2:0]  out_op_kind,
  input wire logic [4:0]  out_ccr_out,
  input wire logic        out_illegal
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result)
      && $stable(out_swap_value) && $stable(out_ccr_out))
    else $error("stalled result changed");

  // Illegal only for exchange
  a_illegal_exg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> out_op_kind == KIND_EXG)
    else $error("illegal flag on non-exchange");

  // Swap value is zero outside exchange
  a_swap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_kind != KIND_EXG |-> out_swap_value == 32'd0)
    else $error("swap value nonzero outside exchange");

  // Logic and multiply clear V and C
  a_vc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_op_kind == KIND_AND_REG || out_op_kind == KIND_AND_MEM
      || out_op_kind == KIND_MULU || out_op_kind == KIND_MULS)
      |-> out_ccr_out[FLAG_V] == 1'b0 && out_ccr_out[FLAG_C] == 1'b0)
    else $error("V or C set after AND or multiply");

endmodule

bind m68k_line_c_execute_core m68kc_checker u_m68kc_checker (.*);

`default_nettype wire

@@ tb/tb_m68k_line_c_execute_core.sv @@
`timescale 1ns / 1ps

module tb_m68k_line_c_execute_core;
  import m68kc_pkg::*;

  localparam int N_DIR        = 25;
  localparam int N_RAND       = 1525;
  localparam int LONG_HOLD    = 64;
  localparam int HOLD_AT      = 400;
  localparam int DRAIN_AT     = 1000;
  localparam int TAIL_CYCLES  = 8;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [31:0] result;
    logic [31:0] swap_value;
    op_kind_t    op_kind;
    logic [4:0]  ccr_out;
    logic        illegal;
  } exec_res_t;

  typedef struct packed {
    logic [7:0]  opword_high;
    logic [7:0]  opword_low;
    logic [31:0] src_value;
    logic [31:0] dst_value;
    logic [4:0]  ccr_in;
    logic        typed;
    exec_res_t   res;
  } stim_row_t;

  localparam exec_res_t NO_RES = '{32'h0, 32'h0, KIND_AND_REG, 5'h00, 1'b0};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_opword_high;
  logic [7:0]  in_opword_low;
  logic [31:0] in_src_value;
  logic [31:0] in_dst_value;
  logic [4:0]  in_ccr_in;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result;
  logic [31:0] out_swap_value;
  logic [2:0]  out_op_kind;
  logic [4:0]  out_ccr_out;
  logic        out_illegal;

  exec_res_t   exec_res_q[$];
  int          err_cnt;
  int          res_cnt;
  int          kind_seen[6];
  int          illegal_seen;
  int          cycle_cnt;
  logic        idle_on;
  logic        long_hold_req;

  // Directed transactions: extremes, every operation and the decimal-adjust corners
  stim_row_t dir_tab [N_DIR] = '{
    '{8'h00, 8'h00, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'h1F, 1'b1,
      '{32'h000000FF, 32'h0, KIND_AND_REG, 5'h18, 1'b0}},
    '{8'h0E, 8'h7F, 32'h0000FFFF, 32'hFFFF8000, 5'h00, 1'b1,
      '{32'h00008000, 32'h0, KIND_AND_REG, 5'h08, 1'b0}},
    '{8'hF0, 8'hBF, 32'hAAAAAAAA, 32'h55555555, 5'h1F, 1'b1,
      '{32'h00000000, 32'h0, KIND_AND_REG, 5'h14, 1'b0}},
    '{8'h00, 8'h80, 32'hFFFFFFFF, 32'h80000001, 5'h0F, 1'b1,
      '{32'h80000001, 32'h0, KIND_AND_REG, 5'h08, 1'b0}},
    '{8'h00, 8'hC0, 32'h1234FFFF, 32'hABCDFFFF, 5'h00, 1'b1,
      '{32'hFFFE0001, 32'h0, KIND_MULU, 5'h08, 1'b0}},
    '{8'hFE, 8'hFF, 32'hFFFF0000, 32'h12345678, 5'h1F, 1'b1,
      '{32'h00000000, 32'h0, KIND_MULU, 5'h14, 1'b0}},
    '{8'h01, 8'hC0, 32'h0000FFFF, 32'hFFFFFFFF, 5'h1F, 1'b1,
      '{32'h00000001, 32'h0, KIND_MULS, 5'h10, 1'b0}},
    '{8'hFF, 8'hFF, 32'h00008000, 32'h00008000, 5'h00, 1'b1,
      '{32'h40000000, 32'h0, KIND_MULS, 5'h00, 1'b0}},
    '{8'h0F, 8'hC7, 32'hFFFF8000, 32'h00007FFF, 5'h0A, 1'b0, NO_RES},
    '{8'h01, 8'hC0, 32'h00000000, 32'h0000FFFF, 5'h0E, 1'b0, NO_RES},
    '{8'h01, 8'h00, 32'h00000099, 32'h00000001, 5'h04, 1'b1,
      '{32'h00000000, 32'h0, KIND_ABCD, 5'h15, 1'b0}},
    '{8'h0F, 8'h0F, 32'hFFFFFF45, 32'hFFFFFF45, 5'h10, 1'b0, NO_RES},
    '{8'hFF, 8'h08, 32'h000000FF, 32'h000000FF, 5'h1F, 1'b0, NO_RES},
    '{8'h01, 8'h01, 32'h00000000, 32'h00000083, 5'h00, 1'b0, NO_RES},
    '{8'h01, 8'h02, 32'h00000079, 32'h00000003, 5'h00, 1'b0, NO_RES},
    '{8'h01, 8'h00, 32'h00000001, 32'h00000000, 5'h1F, 1'b1,
      '{32'h00000002, 32'h0, KIND_ABCD, 5'h00, 1'b0}},
    '{8'h01, 8'h40, 32'h11111111, 32'h22222222, 5'h1B, 1'b1,
      '{32'h11111111, 32'h22222222, KIND_EXG, 5'h1B, 1'b0}},
    '{8'hFF, 8'h4F, 32'hFFFFFFFF, 32'h00000000, 5'h00, 1'b1,
      '{32'hFFFFFFFF, 32'h00000000, KIND_EXG, 5'h00, 1'b0}},
    '{8'h03, 8'h8A, 32'h00000000, 32'hFFFFFFFF, 5'h1F, 1'b1,
      '{32'h00000000, 32'hFFFFFFFF, KIND_EXG, 5'h1F, 1'b0}},
    '{8'h01, 8'h80, 32'h89ABCDEF, 32'h12345678, 5'h15, 1'b1,
      '{32'h12345678, 32'h89ABCDEF, KIND_EXG, 5'h15, 1'b1}},
    '{8'hFF, 8'h87, 32'h00000000, 32'hFFFFFFFF, 5'h0A, 1'b0, NO_RES},
    '{8'h01, 8'h10, 32'hFFFFFF80, 32'h000000FF, 5'h1F, 1'b1,
      '{32'h00000080, 32'h0, KIND_AND_MEM, 5'h18, 1'b0}},
    '{8'h0B, 8'h7F, 32'h1234FFFF, 32'hFFFF0000, 5'h00, 1'b1,
      '{32'h00000000, 32'h0, KIND_AND_MEM, 5'h04, 1'b0}},
    '{8'hFF, 8'hBF, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'h0B, 1'b1,
      '{32'hFFFFFFFF, 32'h0, KIND_AND_MEM, 5'h08, 1'b0}},
    '{8'h00, 8'h3F, 32'h5A5AC3C3, 32'hF0F0FFFF, 5'h1F, 1'b0, NO_RES}
  };

  m68k_line_c_execute_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opword_high (in_opword_high),
    .in_opword_low  (in_opword_low),
    .in_src_value   (in_src_value),
    .in_dst_value   (in_dst_value),
    .in_ccr_in      (in_ccr_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_swap_value (out_swap_value),
    .out_op_kind    (out_op_kind),
    .out_ccr_out    (out_ccr_out),
    .out_illegal    (out_illegal)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // N and Z from the sized value; clear V and C, keep X
  function automatic logic [4:0] nz_update(input logic [4:0] ccr, input logic [31:0] val,
                                           input logic [1:0] size);
    logic [4:0] f;
    f = '0;
    f[FLAG_X] = ccr[FLAG_X];
    case (size)
      SIZE_BYTE: f[FLAG_N] = val[7];
      SIZE_WORD: f[FLAG_N] = val[15];
      default:   f[FLAG_N] = val[31];
    endcase
    f[FLAG_Z] = (val == 32'h0);
    return f;
  endfunction

  function automatic logic [31:0] and_masked(input logic [31:0] a, input logic [31:0] b,
                                             input logic [1:0] size);
    logic [31:0] v;
    v = a & b;
    case (size)
      SIZE_BYTE: v = {24'h0, v[7:0]};
      SIZE_WORD: v = {16'h0, v[15:0]};
      default:   v = v;
    endcase
    return v;
  endfunction

  // Decimal add of the low bytes plus X, with this core's V and sticky-Z rules
  function automatic exec_res_t bcd_sum(input logic [31:0] src, input logic [31:0] dst,
                                        input logic [4:0] ccr);
    exec_res_t  r;
    logic [7:0] s8, d8, digits, v_top;
    logic [5:0] lo_sum;
    logic [9:0] hi_sum;
    logic [4:0] f;
    s8 = src[7:0];
    d8 = dst[7:0];
    lo_sum = {2'b00, s8[3:0]} + {2'b00, d8[3:0]} + {5'b0, ccr[FLAG_X]};
    if (lo_sum >= 6'h0a) lo_sum = lo_sum + 6'h06;
    hi_sum = {2'b00, s8[7:4], 4'h0} + {2'b00, d8[7:4], 4'h0} + {4'h0, lo_sum[5:4], 4'h0};
    if (hi_sum >= 10'h0a0) hi_sum = hi_sum + 10'h060;
    f = '0;
    f[FLAG_Z] = ccr[FLAG_Z];
    if (hi_sum >= 10'h100) begin
      f[FLAG_X] = 1'b1;
      f[FLAG_C] = 1'b1;
    end
    digits = {hi_sum[7:4], lo_sum[3:0]};
    if (digits != 8'h00) f[FLAG_Z] = 1'b0;
    f[FLAG_N] = digits[7];
    if (!d8[7]) v_top = 8'h80 + ((d8[3:0] >= 4'd5) ? 8'd5 : {4'h0, d8[3:0]});
    else v_top = d8;
    if (digits[7] && digits <= v_top) f[FLAG_V] = 1'b1;
    r = NO_RES;
    r.op_kind = KIND_ABCD;
    r.result  = {24'h0, digits};
    r.ccr_out = f;
    return r;
  endfunction

  // Decode one opcode and compute what the core must return for it
  function automatic exec_res_t line_c_outcome(input logic [7:0] hi, input logic [7:0] lo,
                                               input logic [31:0] src,
                                               input logic [31:0] dst,
                                               input logic [4:0] ccr);
    exec_res_t          r;
    logic signed [31:0] a_s, b_s;
    r = NO_RES;
    r.ccr_out = ccr;
    if (!hi[0]) begin
      if (lo[7:6] == SIZE_MUL) begin
        r.op_kind = KIND_MULU;
        r.result  = {16'h0, src[15:0]} * {16'h0, dst[15:0]};
        r.ccr_out = nz_update(ccr, r.result, 2'd2);
      end else begin
        r.op_kind = KIND_AND_REG;
        r.result  = and_masked(src, dst, lo[7:6]);
        r.ccr_out = nz_update(ccr, r.result, lo[7:6]);
      end
    end else if (lo[7:6] == SIZE_MUL) begin
      a_s = {{16{src[15]}}, src[15:0]};
      b_s = {{16{dst[15]}}, dst[15:0]};
      r.op_kind = KIND_MULS;
      r.result  = a_s * b_s;
      r.ccr_out = nz_update(ccr, r.result, 2'd2);
    end else if (lo[7:4] == 4'h0) begin
      r = bcd_sum(src, dst, ccr);
    end else if (lo[5:4] == 2'b00) begin
      r.op_kind = KIND_EXG;
      if (lo[7:3] == EXG_DD || lo[7:3] == EXG_AA || lo[7:3] == EXG_DA) begin
        r.result     = src;
        r.swap_value = dst;
      end else begin
        r.illegal    = 1'b1;
        r.result     = dst;
        r.swap_value = src;
      end
    end else begin
      r.op_kind = KIND_AND_MEM;
      r.result  = and_masked(src, dst, lo[7:6]);
      r.ccr_out = nz_update(ccr, r.result, lo[7:6]);
    end
    return r;
  endfunction

  // Operand mix: corners, sign boundaries, decimal digits and plain random
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h00000000;
      1: v = 32'hFFFFFFFF;
      2: v = {16'($urandom), 1'($urandom), 15'($urandom_range(0, 3))};
      3: v = {24'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      4: v = {24'($urandom), 8'($urandom_range(8'h78, 8'h9F))};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Build a random opcode aimed at one operation, or a fully random pattern
  function automatic stim_row_t random_row();
    stim_row_t row;
    op_kind_t  aim;
    row = '{8'h0, 8'h0, 32'h0, 32'h0, 5'h0, 1'b0, NO_RES};
    aim = op_kind_t'(3'($urandom_range(0, 5)));
    row.opword_high = 8'($urandom);
    row.opword_low  = 8'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      case (aim)
        KIND_AND_REG: begin
          row.opword_high[0] = 1'b0;
          row.opword_low[7:6] = 2'($urandom_range(0, 2));
        end
        KIND_MULU: begin
          row.opword_high[0] = 1'b0;
          row.opword_low[7:6] = SIZE_MUL;
        end
        KIND_MULS: begin
          row.opword_high[0] = 1'b1;
          row.opword_low[7:6] = SIZE_MUL;
        end
        KIND_ABCD: begin
          row.opword_high[0] = 1'b1;
          row.opword_low[7:4] = 4'h0;
        end
        KIND_EXG: begin
          row.opword_high[0] = 1'b1;
          row.opword_low[7:6] = $urandom_range(0, 1) ? 2'b01 : 2'b10;
          row.opword_low[5:4] = 2'b00;
        end
        default: begin
          row.opword_high[0] = 1'b1;
          row.opword_low[7:6] = 2'($urandom_range(0, 2));
          row.opword_low[5:4] = 2'($urandom_range(1, 3));
        end
      endcase
    end
    row.src_value = pick_operand();
    row.dst_value = pick_operand();
    row.ccr_in    = 5'($urandom);
    return row;
  endfunction

  // Offer one transaction, hold it until accepted, then record its outcome
  task automatic send_op(input stim_row_t row);
    in_valid       <= 1'b1;
    in_opword_high <= row.opword_high;
    in_opword_low  <= row.opword_low;
    in_src_value   <= row.src_value;
    in_dst_value   <= row.dst_value;
    in_ccr_in      <= row.ccr_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (row.typed) exec_res_q.push_back(row.res);
    else exec_res_q.push_back(line_c_outcome(row.opword_high, row.opword_low,
                                             row.src_value, row.dst_value, row.ccr_in));
  endtask

  // Idle the sender for the drawn number of cycles
  task automatic sender_gap();
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    stim_row_t row;
    err_cnt        = 0;
    res_cnt        = 0;
    illegal_seen   = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    idle_on        = 1'b1;
    long_hold_req  = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opword_high <= '0;
    in_opword_low  <= '0;
    in_src_value   <= '0;
    in_dst_value   <= '0;
    in_ccr_in      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < N_DIR; i++) begin
      send_op(dir_tab[i]);
      sender_gap();
    end

    // Random transactions, with idle and back-to-back stretches
    for (int i = 0; i < N_RAND; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == HOLD_AT) begin
        idle_on = 1'b0;
        long_hold_req = 1'b1;
      end
      row = random_row();
      send_op(row);
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        while (exec_res_q.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end
    in_valid <= 1'b0;

    // Drain and let the pipeline settle
    while (exec_res_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results (%0d directed, %0d random) with random stalls on both sides",
             res_cnt, N_DIR, N_RAND);
    $display("and_reg %0d, and_mem %0d, mulu %0d, muls %0d, abcd %0d, exg %0d (illegal %0d)",
             kind_seen[KIND_AND_REG], kind_seen[KIND_AND_MEM], kind_seen[KIND_MULU],
             kind_seen[KIND_MULS], kind_seen[KIND_ABCD], kind_seen[KIND_EXG], illegal_seen);
    if (err_cnt == 0 && exec_res_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: short random stalls per result, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on) begin
        int stall;
        stall = $urandom_range(0, 3);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exec_res_q.size() == 0) begin
        $error("unexpected result transaction: result %h", out_result);
        err_cnt++;
      end else begin
        exec_res_t want;
        want = exec_res_q.pop_front();
        res_cnt++;
        kind_seen[want.op_kind]++;
        if (want.illegal) illegal_seen++;
        if (out_result !== want.result) begin
          $error("result: expected %h, got %h", want.result, out_result);
          err_cnt++;
        end
        if (out_swap_value !== want.swap_value) begin
          $error("swap_value: expected %h, got %h", want.swap_value, out_swap_value);
          err_cnt++;
        end
        if (out_op_kind !== want.op_kind) begin
          $error("op_kind: expected %0d, got %0d", want.op_kind, out_op_kind);
          err_cnt++;
        end
        if (out_ccr_out !== want.ccr_out) begin
          $error("ccr_out: expected %h, got %h", want.ccr_out, out_ccr_out);
          err_cnt++;
        end
        if (out_illegal !== want.illegal) begin
          $error("illegal: expected %b, got %b", want.illegal, out_illegal);
          err_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, exec_res_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
